// ===== design/sfpr_pkg.sv =====
// Shared types, constants and helpers for the SysEx firmware page receiver.
// No dependencies; imported by every module of the block.
package sfpr_pkg;

	localparam int PAGE_SIZE  = 256;
	localparam int FILL_W     = $clog2(PAGE_SIZE + 3);
	localparam int IDX_W      = 9;
	localparam int STEP_W     = 10;
	localparam int ADDR_W     = 16;
	localparam int HDR_LEN    = 7;

	// Depth of the queue between front and back, and of the result queue.
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int ODEPTH     = 2;
	localparam int OPTR_W     = $clog2(ODEPTH);

	localparam logic [7:0] BYTE_SYX_END = 8'hF7;
	localparam logic [7:0] BYTE_SYX_ST  = 8'hF0;
	localparam logic [6:0] CMD_RESET    = 7'h7F;
	localparam logic [6:0] CMD_PAGE     = 7'h7E;
	localparam logic [6:0] CMD_SUB      = 7'h00;

	typedef enum logic [1:0] {
		CLS_DATA,    // 0x00..0x7F
		CLS_STATUS,  // 0x80..0xF0
		CLS_END,     // 0xF7
		CLS_RT       // realtime, dropped
	} class_t;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_COMMAND = 3'd1,
		PH_DATA    = 3'd2,
		PH_RESET   = 3'd3,
		PH_ERROR   = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_DATA   = 3'd1,
		EV_COMMIT = 3'd2,
		EV_RESET  = 3'd3,
		EV_ERROR  = 3'd4
	} event_t;

	typedef struct packed {
		class_t     cls;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		event_t              ev;
		logic [7:0]          dbyte;
		logic [IDX_W-1:0]    idx;
		logic [ADDR_W-1:0]   addr;
	} result_t;

	// Expected SysEx header: F0 29 'G' 'A' 'L' 00 00
	function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
		logic [7:0] r;
		unique case (pos)
			3'd0:    r = 8'hF0;
			3'd1:    r = 8'h29;
			3'd2:    r = 8'h47;
			3'd3:    r = 8'h41;
			3'd4:    r = 8'h4C;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== design/sfpr_front.sv =====
// Front end: accepts MIDI bytes, classifies them and queues them for the back end.
// Depends on sfpr_pkg.
module sfpr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     rx_byte,
	input  logic           push,
	output logic           full,
	output sfpr_pkg::item_t q_item,
	output logic           q_valid,
	input  logic           q_take
);
	import sfpr_pkg::*;

	item_t                 cls_item;
	item_t                 queue_q [QDEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QPTR_W:0]       cnt_q;
	logic                  wr_en;
	logic                  rd_en;

	always_comb begin
		cls_item.data = rx_byte;
		if (rx_byte == BYTE_SYX_END) begin
			cls_item.cls = CLS_END;
		end else if (rx_byte > BYTE_SYX_ST) begin
			cls_item.cls = CLS_RT;
		end else if (rx_byte[7]) begin
			cls_item.cls = CLS_STATUS;
		end else begin
			cls_item.cls = CLS_DATA;
		end
	end

	assign full    = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign wr_en   = push && !full;
	assign rd_en   = q_take && q_valid;
	assign q_item  = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(wr_en) - (QPTR_W+1)'(rd_en);
		end
	end

endmodule

// ===== design/sfpr_back.sv =====
// Back end: header/command/data parser state machine and the result queue.
// Depends on sfpr_pkg; fed by sfpr_front.
module sfpr_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sfpr_pkg::item_t        q_item,
	input  logic                   q_valid,
	output logic                   q_take,
	output logic                   empty,
	input  logic                   pop,
	output logic [2:0]             event_res,
	output logic [7:0]             data_byte,
	output logic [sfpr_pkg::IDX_W-1:0]  byte_index,
	output logic [sfpr_pkg::ADDR_W-1:0] page_address
);
	import sfpr_pkg::*;

	phase_t               phase_q, phase_d;
	logic [STEP_W-1:0]    step_q, step_d, step_inc;
	logic [6:0]           cmd1_q, cmd1_d;
	logic [6:0]           cmd2_q, cmd2_d;
	logic [3:0]           hi_q, hi_d;
	logic [FILL_W-1:0]    fill_q, fill_d;
	logic [7:0]           sum_q, sum_d;
	logic [7:0]           last_q, last_d;
	logic [ADDR_W-1:0]    base_q, base_d;
	logic [7:0]           full_byte;
	result_t              res;

	result_t              oq_q [ODEPTH];
	logic [OPTR_W-1:0]    owr_q;
	logic [OPTR_W-1:0]    ord_q;
	logic [OPTR_W:0]      ocnt_q;
	logic                 ofull;
	logic                 opop;

	assign ofull  = (ocnt_q == (OPTR_W+1)'(ODEPTH));
	assign q_take = q_valid && !ofull;
	assign empty  = (ocnt_q == '0);
	assign opop   = pop && !empty;

	assign step_inc  = step_q + 1'b1;
	assign full_byte = {hi_q, q_item.data[3:0]};

	always_comb begin
		phase_d   = phase_q;
		step_d    = step_q;
		cmd1_d    = cmd1_q;
		cmd2_d    = cmd2_q;
		hi_d      = hi_q;
		fill_d    = fill_q;
		sum_d     = sum_q;
		last_d    = last_q;
		base_d    = base_q;
		res.ev    = EV_NONE;
		res.dbyte = '0;
		res.idx   = '0;
		res.addr  = base_q;
		if (q_item.cls != CLS_RT) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (q_item.data == hdr_byte(step_q[2:0])) begin
						if (step_q == STEP_W'(HDR_LEN - 1)) begin
							step_d  = '0;
							phase_d = PH_COMMAND;
						end else begin
							step_d = step_inc;
						end
					end else begin
						// no retry of the offending byte as a header start
						step_d = '0;
					end
				end
				PH_COMMAND: begin
					if (q_item.cls == CLS_DATA) begin
						if (step_q == '0) begin
							cmd1_d = q_item.data[6:0];
							step_d = STEP_W'(1);
						end else begin
							cmd2_d  = q_item.data[6:0];
							step_d  = '0;
							fill_d  = '0;
							sum_d   = '0;
							phase_d = PH_DATA;
						end
					end else begin
						phase_d = PH_HEADER;
						step_d  = '0;
					end
				end
				PH_DATA: begin
					if (q_item.cls == CLS_DATA) begin
						if (step_q[0]) begin
							if (fill_q < FILL_W'(PAGE_SIZE)) begin
								sum_d = sum_q + full_byte;
							end
							last_d    = full_byte;
							res.ev    = EV_DATA;
							res.dbyte = full_byte;
							res.idx   = IDX_W'(fill_q);
							if (fill_q < FILL_W'(PAGE_SIZE + 2)) begin
								fill_d = fill_q + 1'b1;
							end
						end else begin
							hi_d = q_item.data[3:0];
						end
						// wrap skips zero so "no data yet" stays distinct
						step_d = (step_inc == '0) ? STEP_W'(2) : step_inc;
					end else if (q_item.cls == CLS_END) begin
						if (cmd1_q == CMD_RESET && cmd2_q == CMD_SUB && step_q == '0) begin
							res.ev  = EV_RESET;
							phase_d = PH_RESET;
						end else if (fill_q == FILL_W'(PAGE_SIZE + 1) && cmd1_q == CMD_PAGE
								&& cmd2_q == CMD_SUB && last_q == sum_q) begin
							res.ev  = EV_COMMIT;
							base_d  = base_q + ADDR_W'(PAGE_SIZE);
							phase_d = PH_HEADER;
						end else begin
							res.ev  = EV_ERROR;
							phase_d = PH_ERROR;
						end
						step_d = '0;
					end
				end
				default: begin
					// reset done / error: sticky, every beat yields no event
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			step_q  <= '0;
			cmd1_q  <= '0;
			cmd2_q  <= '0;
			hi_q    <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
			last_q  <= '0;
			base_q  <= '0;
		end else if (q_take) begin
			phase_q <= phase_d;
			step_q  <= step_d;
			cmd1_q  <= cmd1_d;
			cmd2_q  <= cmd2_d;
			hi_q    <= hi_d;
			fill_q  <= fill_d;
			sum_q   <= sum_d;
			last_q  <= last_d;
			base_q  <= base_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			oq_q[owr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (q_take) begin
				owr_q <= owr_q + 1'b1;
			end
			if (opop) begin
				ord_q <= ord_q + 1'b1;
			end
			ocnt_q <= ocnt_q + (OPTR_W+1)'(q_take) - (OPTR_W+1)'(opop);
		end
	end

	assign event_res    = oq_q[ord_q].ev;
	assign data_byte    = oq_q[ord_q].dbyte;
	assign byte_index   = oq_q[ord_q].idx;
	assign page_address = oq_q[ord_q].addr;

endmodule

// ===== design/sysex_firmware_page_receiver_top.sv =====
// Top level of the SysEx firmware page receiver.
// Depends on sfpr_pkg, sfpr_front and sfpr_back.
//
// Accepts one MIDI byte per beat and returns exactly one result per byte, in
// order: event, assembled page byte with its index, and the current page
// address. Sustained rate is one byte per cycle in both directions while no
// stall holds it; a result becomes visible once its byte, accepted into the
// 4-deep classified-byte queue, has been consumed by the parser and written
// into the 2-deep result queue. Either side may stall freely: the byte queue
// absorbs result-side stalls until it fills, then full rises.
// After a reset request or an error the parser stays put until arst_n; all
// later bytes still produce a result with event 0.
module sysex_firmware_page_receiver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        push,
	output logic        full,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  event_res,
	output logic [7:0]  data_byte,
	output logic [8:0]  byte_index,
	output logic [15:0] page_address
);
	import sfpr_pkg::*;

	item_t q_item;
	logic  q_valid;
	logic  q_take;

	sfpr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (rx_byte),
		.push    (push),
		.full    (full),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_take  (q_take)
	);

	sfpr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_item       (q_item),
		.q_valid      (q_valid),
		.q_take       (q_take),
		.empty        (empty),
		.pop          (pop),
		.event_res    (event_res),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.page_address (page_address)
	);

endmodule

// ===== design/sfpr_checker.sv =====
// Port-level checks for the SysEx firmware page receiver, bound to the top level.
// Depends on sfpr_pkg.
module sfpr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  event_res,
	input logic [7:0]  data_byte,
	input logic [8:0]  byte_index,
	input logic [15:0] page_address
);
	import sfpr_pkg::*;

	// Result fields hold while a result waits unpopped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(event_res) && $stable(data_byte)
			&& $stable(byte_index) && $stable(page_address))
		else $error("result changed while stalled");

	// Only data beats carry a byte and index.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && event_res != EV_DATA |-> data_byte == 8'd0 && byte_index == 9'd0)
		else $error("payload on a non-data beat");

	// Page address only moves across a commit, by one page.
	a_addr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && event_res != EV_COMMIT ##1 !empty
			|-> page_address == $past(page_address))
		else $error("page address moved without commit");

	a_addr_step: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && event_res == EV_COMMIT ##1 !empty
			|-> page_address == $past(page_address) + ADDR_W'(PAGE_SIZE))
		else $error("page address did not advance on commit");

endmodule

bind sysex_firmware_page_receiver_top sfpr_checker u_sfpr_checker (.*);

// ===== verif/sfpr_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the SysEx firmware page receiver: predicts one result per
// accepted MIDI byte and compares each popped result with it, in order.
// Depends on sfpr_pkg for the result struct, phase and event codes.
module sfpr_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        pop,
	input  logic        empty,
	input  logic [2:0]  event_res,
	input  logic [7:0]  data_byte,
	input  logic [8:0]  byte_index,
	input  logic [15:0] page_address,
	output int          mismatch_count,
	output int          outstanding
);
	import sfpr_pkg::*;

	localparam logic [55:0] HDR_SEQ = 56'hF0_29_47_41_4C_00_00;

	phase_t      parse_phase;
	logic [9:0]  step_cnt;
	logic [6:0]  op_first;
	logic [6:0]  op_second;
	logic [3:0]  pend_nibble;
	int          fill_cnt;
	logic [7:0]  page_sum;
	logic [7:0]  last_assembled;
	logic [15:0] page_base;
	result_t     pending_results[$];

	function automatic result_t decode_midi_byte(input logic [7:0] b);
		result_t    r;
		logic [7:0] assembled;
		int         pos;
		r.ev    = EV_NONE;
		r.dbyte = '0;
		r.idx   = '0;
		r.addr  = page_base;
		pos     = int'(step_cnt);
		if (b > BYTE_SYX_ST && b != BYTE_SYX_END) begin
			// realtime, dropped everywhere
		end else begin
			case (parse_phase)
				PH_HEADER: begin
					if (pos < HDR_LEN && b == HDR_SEQ[8*(HDR_LEN-1-pos) +: 8]) begin
						step_cnt = step_cnt + 10'd1;
						if (step_cnt == HDR_LEN) begin
							step_cnt    = '0;
							parse_phase = PH_COMMAND;
						end
					end else begin
						// mismatching byte is not retried as a first byte
						step_cnt = '0;
					end
				end
				PH_COMMAND: begin
					if (!b[7]) begin
						if (step_cnt == '0) begin
							op_first = b[6:0];
							step_cnt = 10'd1;
						end else begin
							op_second   = b[6:0];
							step_cnt    = '0;
							fill_cnt    = 0;
							page_sum    = '0;
							parse_phase = PH_DATA;
						end
					end else begin
						parse_phase = PH_HEADER;
						step_cnt    = '0;
					end
				end
				PH_DATA: begin
					if (!b[7]) begin
						if (step_cnt[0]) begin
							assembled = {pend_nibble, b[3:0]};
							if (fill_cnt < PAGE_SIZE)
								page_sum = page_sum + assembled;
							last_assembled = assembled;
							r.ev    = EV_DATA;
							r.dbyte = assembled;
							r.idx   = fill_cnt[IDX_W-1:0];
							if (fill_cnt < PAGE_SIZE + 2)
								fill_cnt++;
						end else begin
							pend_nibble = b[3:0];
						end
						// nibble counter wraps to 2 so it stays odd/even and nonzero
						step_cnt = step_cnt + 10'd1;
						if (step_cnt == '0)
							step_cnt = 10'd2;
					end else if (b == BYTE_SYX_END) begin
						if (op_first == CMD_RESET && op_second == CMD_SUB && step_cnt == '0) begin
							r.ev        = EV_RESET;
							parse_phase = PH_RESET;
						end else if (fill_cnt == PAGE_SIZE + 1 && op_first == CMD_PAGE &&
								op_second == CMD_SUB && last_assembled == page_sum) begin
							r.ev        = EV_COMMIT;
							page_base   = page_base + 16'(PAGE_SIZE);
							parse_phase = PH_HEADER;
						end else begin
							r.ev        = EV_ERROR;
							parse_phase = PH_ERROR;
						end
						step_cnt = '0;
					end
					// other status bytes are ignored while reading data
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want;
		bit      bad;
		int      errs;
		if (!arst_n) begin
			parse_phase    = PH_HEADER;
			step_cnt       = '0;
			op_first       = '0;
			op_second      = '0;
			pend_nibble    = '0;
			fill_cnt       = 0;
			page_sum       = '0;
			last_assembled = '0;
			page_base      = '0;
			pending_results.delete();
			mismatch_count <= 0;
			outstanding    <= 0;
		end else begin
			errs = 0;
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result beat with none expected: event_res=%0d",
						$time, event_res);
					$display("%0t:   data_byte=%0h byte_index=%0d page_address=%0h",
						$time, data_byte, byte_index, page_address);
					errs++;
				end else begin
					want = pending_results.pop_front();
					bad  = 0;
					if (event_res !== want.ev) begin
						$display("%0t: event_res expected %0d, got %0d", $time, want.ev, event_res);
						bad = 1;
					end
					if (data_byte !== want.dbyte) begin
						$display("%0t: data_byte expected %0h, got %0h", $time, want.dbyte, data_byte);
						bad = 1;
					end
					if (byte_index !== want.idx) begin
						$display("%0t: byte_index expected %0d, got %0d", $time, want.idx, byte_index);
						bad = 1;
					end
					if (page_address !== want.addr) begin
						$display("%0t: page_address expected %0h, got %0h", $time, want.addr,
							page_address);
						bad = 1;
					end
					if (bad)
						errs++;
				end
			end
			if (push && !full)
				pending_results.push_back(decode_midi_byte(rx_byte));
			outstanding    <= pending_results.size();
			mismatch_count <= mismatch_count + errs;
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top for the SysEx firmware page receiver: clock, reset, MIDI byte
// stimulus, result-side flow control, watchdog and verdict.
// Depends on sfpr_pkg, sfpr_result_checker and sysex_firmware_page_receiver_top.
module testbench;
	import sfpr_pkg::*;

	localparam logic [55:0] HDR_SEQ = 56'hF0_29_47_41_4C_00_00;
	localparam int STALL_LIMIT    = 2000;
	localparam int HOLD_AT_RESULT = 300;
	localparam int HOLD_CYCLES    = 80;
	localparam int DIRECTED_LEN   = 25;
	localparam int RANDOM_BYTES   = 100;

	// realtime/extremes, header mismatch without retry, status and F7 aborting a command
	localparam logic [8*DIRECTED_LEN-1:0] DIRECTED_BYTES = {
		8'hF8, 8'hFF, 8'h00, 8'h80,
		8'hF0, 8'hF0, 8'h29, 8'h47,
		8'hF0, 8'h29, 8'h47, 8'h41, 8'h4C, 8'h00, 8'h00, 8'h7E, 8'h90,
		8'hF0, 8'h29, 8'h47, 8'h41, 8'h4C, 8'h00, 8'h00, 8'hF7
	};

	typedef enum int {
		FR_COMMIT,
		FR_BAD_SUM,
		FR_SHORT,
		FR_LONG,
		FR_BAD_CMD,
		FR_ODD_NIBBLE,
		FR_RESET_DATA,
		FR_RESET
	} frame_kind_t;

	logic        clk;
	logic        arst_n;
	logic [7:0]  rx_byte;
	logic        push;
	logic        full;
	logic        empty;
	logic        pop;
	logic [2:0]  event_res;
	logic [7:0]  data_byte;
	logic [8:0]  byte_index;
	logic [15:0] page_address;
	int          mismatch_count;
	int          outstanding;
	int          bytes_sent    = 0;
	int          results_taken = 0;
	int          quiet_cycles  = 0;
	bit          tx_idle_en;
	bit          rx_idle_en;

	sysex_firmware_page_receiver_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (rx_byte),
		.push         (push),
		.full         (full),
		.empty        (empty),
		.pop          (pop),
		.event_res    (event_res),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.page_address (page_address)
	);

	sfpr_result_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.rx_byte        (rx_byte),
		.pop            (pop),
		.empty          (empty),
		.event_res      (event_res),
		.data_byte      (data_byte),
		.byte_index     (byte_index),
		.page_address   (page_address),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random gaps, plus one long hold-off so full gets exercised
	initial begin : result_side
		int gap;
		pop <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			gap = rx_idle_en ? $urandom_range(0, 7) : 0;
			if (results_taken == HOLD_AT_RESULT) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do
				@(posedge clk);
			while (empty);
			results_taken++;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (full);
		bytes_sent++;
	endtask

	// occasionally slips in a realtime byte, and a stray status while in data
	task automatic send_midi(input logic [7:0] b, input bit in_data);
		if ($urandom_range(0, 31) == 0)
			send_byte($urandom_range(0, 1) ? 8'($urandom_range(8'hF8, 8'hFF)) :
				8'($urandom_range(8'hF1, 8'hF6)));
		if (in_data && $urandom_range(0, 31) == 0)
			send_byte(8'($urandom_range(8'h80, 8'hF0)));
		send_byte(b);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic send_header();
		for (int i = 0; i < HDR_LEN; i++)
			send_midi(HDR_SEQ[8*(HDR_LEN-1-i) +: 8], 1'b0);
	endtask

	// one page byte as two nibble beats, upper bits of each beat random
	task automatic send_page_byte(input logic [7:0] val);
		send_midi({1'b0, 3'($urandom), val[7:4]}, 1'b1);
		send_midi({1'b0, 3'($urandom), val[3:0]}, 1'b1);
	endtask

	task automatic send_frame(input frame_kind_t kind);
		logic [6:0] op_a;
		logic [6:0] op_b;
		logic [7:0] sum;
		logic [7:0] val;
		int         n_bytes;
		op_a    = CMD_PAGE;
		op_b    = CMD_SUB;
		n_bytes = PAGE_SIZE + 1;
		sum     = '0;
		case (kind)
			FR_SHORT: n_bytes = $urandom_range(0, PAGE_SIZE);
			FR_LONG: begin
				// 2*PAGE_SIZE bytes and up also wrap the nibble counter
				if ($urandom_range(0, 1))
					n_bytes = 2 * PAGE_SIZE + $urandom_range(0, 8);
				else
					n_bytes = $urandom_range(PAGE_SIZE + 2, 2 * PAGE_SIZE);
			end
			FR_BAD_CMD: begin
				op_a = 7'($urandom);
				op_b = 7'($urandom_range(1, 127));
			end
			FR_ODD_NIBBLE: begin
				op_a    = $urandom_range(0, 1) ? CMD_RESET : CMD_PAGE;
				n_bytes = $urandom_range(0, 2);
			end
			FR_RESET_DATA: begin
				op_a    = CMD_RESET;
				n_bytes = $urandom_range(1, 3);
			end
			FR_RESET: begin
				op_a    = CMD_RESET;
				n_bytes = 0;
			end
			default: ;
		endcase
		send_header();
		send_midi({1'b0, op_a}, 1'b0);
		send_midi({1'b0, op_b}, 1'b0);
		for (int i = 0; i < n_bytes; i++) begin
			val = 8'($urandom);
			if (i == PAGE_SIZE)
				val = (kind == FR_BAD_SUM) ? sum + 8'($urandom_range(1, 255)) : sum;
			if (i < PAGE_SIZE)
				sum = sum + val;
			send_page_byte(val);
		end
		if (kind == FR_ODD_NIBBLE)
			send_midi({1'b0, 3'($urandom), 4'($urandom)}, 1'b1);
		send_midi(BYTE_SYX_END, 1'b1);
	endtask

	// random bytes, closed by a status byte so the next header starts clean
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 8);
		repeat (n) send_byte(8'($urandom));
		send_byte(8'($urandom_range(8'h80, 8'hEF)));
	endtask

	task automatic send_broken_header();
		int         k;
		logic [7:0] miss;
		k = $urandom_range(1, HDR_LEN - 1);
		for (int i = 0; i < k; i++)
			send_midi(HDR_SEQ[8*(HDR_LEN-1-i) +: 8], 1'b0);
		miss = 8'($urandom_range(0, 8'hF0));
		if (miss == HDR_SEQ[8*(HDR_LEN-1-k) +: 8])
			miss = miss ^ 8'h01;
		send_byte(miss);
	endtask

	task automatic send_aborted_command();
		send_header();
		if ($urandom_range(0, 1))
			send_midi({1'b0, 7'($urandom)}, 1'b0);
		send_byte(($urandom_range(0, 3) == 0) ? BYTE_SYX_END :
			8'($urandom_range(8'h80, 8'hF0)));
	endtask

	initial begin : byte_side
		arst_n     <= 1'b0;
		push       <= 1'b0;
		rx_byte    <= '0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_LEN; i++)
			send_byte(DIRECTED_BYTES[8*(DIRECTED_LEN-1-i) +: 8]);
		wait_drained();

		// mixed noise, broken headers and aborted commands
		while (bytes_sent < DIRECTED_LEN + RANDOM_BYTES) begin
			tx_idle_en = $urandom_range(0, 3) != 0;
			rx_idle_en = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 4))
				0, 1:    send_noise();
				2, 3:    send_broken_header();
				default: send_aborted_command();
			endcase
		end
		wait_drained();

		// one full page commit at full input rate; the long result hold-off falls in it
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b1;
		send_frame(FR_COMMIT);
		wait_drained();

		// one terminal frame, then bytes that must all come back as no event
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		if ($urandom_range(0, 1))
			send_frame(FR_RESET);
		else
			send_frame(frame_kind_t'($urandom_range(FR_ODD_NIBBLE, FR_RESET_DATA)));
		repeat (30) send_byte(8'($urandom));
		send_frame(FR_RESET);
		wait_drained();
		repeat (16) @(posedge clk);

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
